>>> rtl/wdf_pkg.sv
// Package with the shared types and codes of the watchdog with fallback stage.
`default_nettype none

package wdf_pkg;

  // Command codes carried by an input transfer.
  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_ENABLE = 2'd1,
    CMD_KICK   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  // Configuration register indexes.
  localparam int unsigned CfgIndexWidth = 3;
  localparam logic [CfgIndexWidth-1:0] REG_INTERVAL          = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_EXPIRE_ACTION     = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_FALLBACK_PRESENT  = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_FALLBACK_INTERVAL = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_FALLBACK_ACTION   = 3'd4;
  localparam logic [CfgIndexWidth-1:0] REG_FALLBACK_ALWAYS   = 3'd5;
  localparam logic [CfgIndexWidth-1:0] REG_TARGET_MASK       = 3'd6;

  localparam int unsigned CfgDataWidth = 32;

  // Reset values of the configuration registers.
  localparam logic [31:0] RST_INTERVAL    = 32'd30000;
  localparam logic [1:0]  RST_EXPIRE_ACT  = 2'd1;
  localparam logic [3:0]  RST_TARGET_MASK = 4'd14;

  // Configuration as seen by the step logic.
  typedef struct packed {
    logic [31:0] primary_timeout;
    logic [1:0]  expire_action;
    logic        fallback_present;
    logic [31:0] fallback_timeout;
    logic [1:0]  fallback_action;
    logic        fallback_always;
    logic [3:0]  target_mask;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [31:0] time_left_ms;
    logic        shown_enabled;
    logic        counting;
    logic        action_fired;
    logic [1:0]  fired_action;
  } res_t;

endpackage

`default_nettype wire

>>> rtl/wdf_if.sv
// Valid/ready channel interfaces for commands and results.
`default_nettype none

interface wdf_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] operand_value;

  modport source (output valid, output command, output operand_value, input ready);
  modport sink   (input valid, input command, input operand_value, output ready);
endinterface

interface wdf_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_left_ms;
  logic        shown_enabled;
  logic        counting;
  logic        action_fired;
  logic [1:0]  fired_action;

  modport source (output valid, output time_left_ms, output shown_enabled,
                  output counting, output action_fired, output fired_action,
                  input ready);
  modport sink   (input valid, input time_left_ms, input shown_enabled,
                  input counting, input action_fired, input fired_action,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/wdf_cfg_regs.sv
// Configuration register file of the watchdog.
`default_nettype none

module wdf_cfg_regs
  import wdf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write_en,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_write_data,
  output cfg_t                          cfg
);

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.primary_timeout  <= RST_INTERVAL;
      cfg.expire_action    <= RST_EXPIRE_ACT;
      cfg.fallback_present <= 1'b0;
      cfg.fallback_timeout <= 32'd0;
      cfg.fallback_action  <= 2'd0;
      cfg.fallback_always  <= 1'b0;
      cfg.target_mask      <= RST_TARGET_MASK;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_INTERVAL:          cfg.primary_timeout  <= cfg_write_data;
        REG_EXPIRE_ACTION:     cfg.expire_action    <= cfg_write_data[1:0];
        REG_FALLBACK_PRESENT:  cfg.fallback_present <= cfg_write_data[0];
        REG_FALLBACK_INTERVAL: cfg.fallback_timeout <= cfg_write_data;
        REG_FALLBACK_ACTION:   cfg.fallback_action  <= cfg_write_data[1:0];
        REG_FALLBACK_ALWAYS:   cfg.fallback_always  <= cfg_write_data[0];
        REG_TARGET_MASK:       cfg.target_mask      <= cfg_write_data[3:0];
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/wdf_engine.sv
// Countdown state and the single-pass step logic of one command.
`default_nettype none

module wdf_engine
  import wdf_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step_en,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] operand_value,
  input  wire cfg_t        cfg,
  output res_t             result
);

  // Largest count; the shift wraps to zero at 64 bits, which still gives all ones.
  localparam logic [63:0] CntMax = (64'd1 << COUNT_WIDTH) - 64'd1;
  localparam logic [63:0] OutMax = 64'h0000_0000_FFFF_FFFF;

  logic [COUNT_WIDTH-1:0] countdown, countdown_next;
  logic                   running, running_next;
  logic                   enabled_flag, enabled_flag_next;

  logic [COUNT_WIDTH-1:0] load_fallback;
  logic [COUNT_WIDTH-1:0] load_interval;
  logic [COUNT_WIDTH-1:0] load_operand;
  logic [1:0]             timeout_action;
  logic                   fired;
  logic [1:0]             act;
  logic [63:0]            count_wide;

  // Saturate a 32-bit load to the counter range.
  function automatic logic [COUNT_WIDTH-1:0] clamp_load(input logic [31:0] v);
    logic [63:0] v_wide;
    v_wide = 64'(v);
    if (v_wide > CntMax) begin
      clamp_load = COUNT_WIDTH'(CntMax);
    end else begin
      clamp_load = COUNT_WIDTH'(v_wide);
    end
  endfunction

  assign load_fallback  = clamp_load(cfg.fallback_timeout);
  assign load_interval  = clamp_load(cfg.primary_timeout);
  assign load_operand   = clamp_load(operand_value);
  assign timeout_action = enabled_flag ? cfg.expire_action : cfg.fallback_action;

  // Next state and fire decision for the command in the input register.
  always_comb begin
    countdown_next    = countdown;
    running_next      = running;
    enabled_flag_next = enabled_flag;
    fired             = 1'b0;
    act               = 2'd0;
    case (cmd_t'(command))
      CMD_TICK: begin
        if (running) begin
          if (countdown > COUNT_WIDTH'(1)) begin
            countdown_next = countdown - COUNT_WIDTH'(1);
          end else begin
            countdown_next = '0;
            running_next   = 1'b0;
            // A timeout without a target stops the count and tries nothing else.
            if (cfg.target_mask[timeout_action]) begin
              fired = 1'b1;
              act   = timeout_action;
              if (cfg.fallback_present && (cfg.fallback_always || enabled_flag)) begin
                countdown_next    = load_fallback;
                running_next      = 1'b1;
                enabled_flag_next = 1'b0;
              end
            end
          end
        end
      end
      CMD_ENABLE: begin
        if (!operand_value[0]) begin
          // Disable clears the flag first, so only an always-on fallback re-arms.
          enabled_flag_next = 1'b0;
          if (cfg.fallback_present && cfg.fallback_always) begin
            countdown_next = load_fallback;
            running_next   = 1'b1;
          end else begin
            running_next = 1'b0;
          end
        end else begin
          if (!enabled_flag) begin
            countdown_next = load_interval;
            running_next   = 1'b1;
          end
          enabled_flag_next = 1'b1;
        end
      end
      CMD_KICK: begin
        if (running) begin
          countdown_next = enabled_flag ? load_operand : load_fallback;
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields after this step.
  assign count_wide = 64'(countdown_next);

  always_comb begin
    if (!running_next) begin
      result.time_left_ms = 32'd0;
    end else if (count_wide > OutMax) begin
      result.time_left_ms = 32'hFFFF_FFFF;
    end else begin
      result.time_left_ms = count_wide[31:0];
    end
    result.shown_enabled = enabled_flag_next;
    result.counting      = running_next;
    result.action_fired  = fired;
    result.fired_action  = act;
  end

  // State registers advance once per processed command.
  always_ff @(posedge clk) begin
    if (rst) begin
      countdown    <= '0;
      running      <= 1'b0;
      enabled_flag <= 1'b0;
    end else if (step_en) begin
      countdown    <= countdown_next;
      running      <= running_next;
      enabled_flag <= enabled_flag_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/watchdog_with_fallback_top.sv
// Top level of the millisecond watchdog with fallback stage.
//
// Commands arrive on the cmd channel (tick, set enable, kick, read) and each
// one gives exactly one result transfer on the res channel: the remaining
// time, the enabled flag as software sees it, whether the count runs, and
// the action fired by a timeout in that step.
// Configuration registers are written through cfg_write_en, cfg_index and cfg_write_data, and there
// is no read-back; the user must write them only while no command is in flight, as the block does not enforce it.
// A command is taken into an input register, processed in one pass against
// the countdown state, and its result is held in an output register. The
// result is transferred from the output register, and one command per cycle
// is sustained while the receiver takes every result; the countdown state,
// updated in a single pass per command, sets that rate.
// While the receiver stalls, the result stays in the output register and one
// more command waits in the input register; cmd.ready falls only then.
// Synchronous reset empties both registers, stops the countdown, clears the
// enabled flag and restores the register reset values.
`default_nettype none

module watchdog_with_fallback_top
  import wdf_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  wdf_cmd_if.sink                       cmd,
  wdf_res_if.source                     res,
  input  wire logic                     cfg_write_en,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [CfgDataWidth-1:0]  cfg_write_data
);

  cfg_t        cfg;
  res_t        step_result;
  res_t        res_data;
  logic        res_valid;
  logic        in_valid;
  logic [1:0]  in_command;
  logic [31:0] in_operand;
  logic        out_free;
  logic        step_en;

  wdf_cfg_regs u_cfg_regs (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_write_data (cfg_write_data),
    .cfg            (cfg)
  );

  wdf_engine #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .step_en       (step_en),
    .command       (in_command),
    .operand_value (in_operand),
    .cfg           (cfg),
    .result        (step_result)
  );

  // Flow control between the input and output registers.
  assign out_free  = !res_valid || res.ready;
  assign step_en   = in_valid && out_free;
  assign cmd.ready = !in_valid || out_free;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_command <= cmd.command;
      in_operand <= cmd.operand_value;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_free) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_data <= step_result;
    end
  end

  assign res.valid         = res_valid;
  assign res.time_left_ms  = res_data.time_left_ms;
  assign res.shown_enabled = res_data.shown_enabled;
  assign res.counting      = res_data.counting;
  assign res.action_fired  = res_data.action_fired;
  assign res.fired_action  = res_data.fired_action;

endmodule

`default_nettype wire

>>> rtl/wdf_checker.sv
// Port-level assertions for the watchdog top level and their bind.
`default_nettype none

module wdf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cmd_ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [31:0] res_time_left_ms,
  input wire logic        res_counting,
  input wire logic        res_action_fired,
  input wire logic [1:0]  res_fired_action
);

  // A stalled result holds its payload.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_time_left_ms)
      && $stable(res_counting) && $stable(res_action_fired)
      && $stable(res_fired_action))
    else $error("stalled result changed");

  // A stopped countdown reports no time left.
  a_stopped_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_counting |-> res_time_left_ms == 32'd0)
    else $error("time left while stopped");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // Both registers are empty after reset, so commands are taken at once.
  a_ready_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> cmd_ready)
    else $error("not ready after reset");

endmodule

bind watchdog_with_fallback_top wdf_checker u_wdf_checker (
  .clk              (clk),
  .rst              (rst),
  .cmd_ready        (cmd.ready),
  .res_valid        (res.valid),
  .res_ready        (res.ready),
  .res_time_left_ms (res.time_left_ms),
  .res_counting     (res.counting),
  .res_action_fired (res.action_fired),
  .res_fired_action (res.fired_action)
);

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the millisecond watchdog with fallback stage.
`default_nettype none

module tb_top;
  import wdf_pkg::*;

  // Run control: no-progress limit, length of the forced result hold-off, random phase size and count, report limit.
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 110;
  localparam int unsigned RandPhases  = 12;
  localparam int unsigned MaxReported = 50;

  // Traffic shaping modes for the two channels.
  typedef enum int unsigned {
    PACE_FULL,
    PACE_SRC_IDLE,
    PACE_SINK_STALL,
    PACE_BOTH
  } pace_t;

  typedef struct {
    cmd_t        op;
    logic [31:0] arg;
  } wd_cmd_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write_en;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_write_data;

  wdf_cmd_if cmd_ch ();
  wdf_res_if res_ch ();

  watchdog_with_fallback_top dut (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .res            (res_ch),
    .cfg_write_en   (cfg_write_en),
    .cfg_index      (cfg_index),
    .cfg_write_data (cfg_write_data)
  );

  always #5 clk = ~clk;

  // Commands waiting to be sent and status words still owed by the block.
  wd_cmd_t cmd_backlog[$];
  res_t    status_due[$];

  // Mirror of the watchdog: configuration and countdown state.
  cfg_t        wd_cfg;
  logic [31:0] wd_count;
  logic        wd_running;
  logic        wd_enabled;

  pace_t pace;
  logic  hold_request;
  logic  sink_hold;

  int unsigned queued_total;
  int unsigned cmds_accepted;
  int unsigned results_checked;
  int unsigned fired_count;
  int unsigned settings_count;
  int unsigned input_stall_cycles;
  int unsigned error_count;
  int unsigned idle_cycles;

  // Enters the fallback stage when one exists and is allowed, else stops.
  function automatic void rearm_or_stop();
    if (wd_cfg.fallback_present && (wd_cfg.fallback_always || wd_enabled)) begin
      wd_count   = wd_cfg.fallback_timeout;
      wd_running = 1'b1;
      wd_enabled = 1'b0;
    end else begin
      wd_running = 1'b0;
    end
  endfunction

  // Applies one command to the mirrored state and returns the status it yields.
  function automatic res_t next_watchdog_status(cmd_t op, logic [31:0] arg);
    res_t       st;
    logic       fired;
    logic [1:0] act;
    fired = 1'b0;
    act   = 2'd0;
    case (op)
      CMD_TICK: begin
        if (wd_running) begin
          if (wd_count > 32'd1) begin
            wd_count = wd_count - 32'd1;
          end else begin
            act        = wd_enabled ? wd_cfg.expire_action : wd_cfg.fallback_action;
            wd_count   = 32'd0;
            wd_running = 1'b0;
            // A timeout whose action has no target just stops the count.
            if (wd_cfg.target_mask[act]) begin
              fired = 1'b1;
              rearm_or_stop();
            end
          end
        end
      end
      CMD_ENABLE: begin
        if (!arg[0]) begin
          wd_enabled = 1'b0;
          rearm_or_stop();
        end else begin
          if (!wd_enabled) begin
            wd_count   = wd_cfg.primary_timeout;
            wd_running = 1'b1;
          end
          wd_enabled = 1'b1;
        end
      end
      CMD_KICK: begin
        // In the fallback stage a kick reloads the fallback interval.
        if (wd_running) begin
          wd_count = wd_enabled ? arg : wd_cfg.fallback_timeout;
        end
      end
      CMD_READ: ;
      default: ;
    endcase
    st.time_left_ms  = wd_running ? wd_count : 32'd0;
    st.shown_enabled = wd_enabled;
    st.counting      = wd_running;
    st.action_fired  = fired;
    st.fired_action  = fired ? act : 2'd0;
    return st;
  endfunction

  function automatic logic source_idle();
    case (pace)
      PACE_SRC_IDLE: return $urandom_range(99) < 85;
      PACE_BOTH:     return $urandom_range(99) < 29;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic logic sink_stall();
    case (pace)
      PACE_SINK_STALL: return $urandom_range(99) < 85;
      PACE_BOTH:       return $urandom_range(99) < 29;
      default:         return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < MaxReported) begin
      $display("MISMATCH @%0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    end
    error_count++;
  endtask

  // Command driver: records each transfer and offers the next backlog entry.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        status_due.push_back(next_watchdog_status(cmd_backlog[0].op, cmd_backlog[0].arg));
        void'(cmd_backlog.pop_front());
        cmds_accepted++;
      end
      if (!(cmd_ch.valid && !cmd_ch.ready)) begin
        if (cmd_backlog.size() > 0 && !source_idle()) begin
          cmd_ch.valid         <= 1'b1;
          cmd_ch.command       <= cmd_backlog[0].op;
          cmd_ch.operand_value <= cmd_backlog[0].arg;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Status monitor: compares every result transfer with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (status_due.size() == 0) begin
          report_mismatch("unexpected result, time_left_ms", res_ch.time_left_ms, 32'd0);
        end else begin
          if (res_ch.time_left_ms !== status_due[0].time_left_ms)
            report_mismatch("time_left_ms", res_ch.time_left_ms, status_due[0].time_left_ms);
          if (res_ch.shown_enabled !== status_due[0].shown_enabled)
            report_mismatch("shown_enabled", 32'(res_ch.shown_enabled),
                            32'(status_due[0].shown_enabled));
          if (res_ch.counting !== status_due[0].counting)
            report_mismatch("counting", 32'(res_ch.counting), 32'(status_due[0].counting));
          if (res_ch.action_fired !== status_due[0].action_fired)
            report_mismatch("action_fired", 32'(res_ch.action_fired),
                            32'(status_due[0].action_fired));
          if (res_ch.fired_action !== status_due[0].fired_action)
            report_mismatch("fired_action", 32'(res_ch.fired_action),
                            32'(status_due[0].fired_action));
          if (status_due[0].action_fired) fired_count++;
          void'(status_due.pop_front());
          results_checked++;
        end
      end
      res_ch.ready <= !sink_hold && !sink_stall();
    end
  end

  // Long result hold-off so that the block fills and pushes back on commands.
  initial begin
    sink_hold = 1'b0;
    wait (hold_request);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Progress watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (cmd_ch.valid && !cmd_ch.ready) input_stall_cycles++;
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
        $display("Timeout: no transfer for %0d cycles", idle_cycles);
        $display("[watchdog_with_fallback_top] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic queue_cmd(cmd_t op, logic [31:0] arg);
    wd_cmd_t c;
    c.op  = op;
    c.arg = arg;
    cmd_backlog.push_back(c);
    queued_total++;
  endtask

  // Mostly short times so that timeouts happen, sometimes the extremes.
  function automatic logic [31:0] pick_time();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 7) return $urandom_range(12);
    if (r == 7) return 32'd0;
    if (r == 8) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t s;
    s.primary_timeout  = pick_time();
    s.expire_action    = 2'($urandom_range(3));
    s.fallback_present = $urandom_range(99) < 70;
    s.fallback_timeout = pick_time();
    s.fallback_action  = 2'($urandom_range(3));
    s.fallback_always  = 1'($urandom_range(1));
    s.target_mask      = ($urandom_range(99) < 40) ? 4'hF : 4'($urandom_range(15));
    return s;
  endfunction

  // One register write per clock; the mirror follows at once since no command is in flight.
  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_index      <= idx;
    cfg_write_data <= data;
    case (idx)
      REG_INTERVAL:          wd_cfg.primary_timeout  = data;
      REG_EXPIRE_ACTION:     wd_cfg.expire_action    = data[1:0];
      REG_FALLBACK_PRESENT:  wd_cfg.fallback_present = data[0];
      REG_FALLBACK_INTERVAL: wd_cfg.fallback_timeout = data;
      REG_FALLBACK_ACTION:   wd_cfg.fallback_action  = data[1:0];
      REG_FALLBACK_ALWAYS:   wd_cfg.fallback_always  = data[0];
      REG_TARGET_MASK:       wd_cfg.target_mask      = data[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(REG_INTERVAL, s.primary_timeout);
    write_reg(REG_EXPIRE_ACTION, {30'd0, s.expire_action});
    write_reg(REG_FALLBACK_PRESENT, {31'd0, s.fallback_present});
    write_reg(REG_FALLBACK_INTERVAL, s.fallback_timeout);
    write_reg(REG_FALLBACK_ACTION, {30'd0, s.fallback_action});
    write_reg(REG_FALLBACK_ALWAYS, {31'd0, s.fallback_always});
    write_reg(REG_TARGET_MASK, {28'd0, s.target_mask});
    @(posedge clk);
    cfg_write_en <= 1'b0;
    settings_count++;
  endtask

  // Waits until every command has gone out and every status has come back.
  task automatic wait_quiet();
    while (cmd_backlog.size() != 0 || status_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Mostly enable-then-count sequences with random content, plus raw noise.
  task automatic queue_random_commands(int unsigned amount);
    int unsigned start;
    int unsigned steps;
    int unsigned pick;
    start = queued_total;
    while (queued_total - start < amount) begin
      if ($urandom_range(99) < 75) begin
        queue_cmd(CMD_ENABLE, $urandom | 32'd1);
        steps = $urandom_range(15);
        repeat (steps) begin
          pick = $urandom_range(99);
          if (pick < 70)      queue_cmd(CMD_TICK, $urandom);
          else if (pick < 82) queue_cmd(CMD_KICK, pick_time());
          else if (pick < 90) queue_cmd(CMD_READ, $urandom);
          else if (pick < 95) queue_cmd(CMD_ENABLE, $urandom | 32'd1);
          else                queue_cmd(CMD_ENABLE, $urandom & ~32'd1);
        end
        if ($urandom_range(99) < 30) queue_cmd(CMD_ENABLE, $urandom & ~32'd1);
      end else begin
        repeat ($urandom_range(1, 4)) queue_cmd(cmd_t'($urandom_range(3)), $urandom);
      end
    end
  endtask

  // Stimulus: reset, directed checks of the corner cases, then random phases.
  initial begin
    cfg_t s;
    rst                  = 1'b1;
    cmd_ch.valid         = 1'b0;
    cmd_ch.command       = CMD_TICK;
    cmd_ch.operand_value = 32'd0;
    res_ch.ready         = 1'b0;
    cfg_write_en         = 1'b0;
    cfg_index            = REG_INTERVAL;
    cfg_write_data       = '0;
    hold_request         = 1'b0;
    pace                 = PACE_FULL;
    wd_cfg     = '{RST_INTERVAL, RST_EXPIRE_ACT, 1'b0, 32'd0, 2'd0, 1'b0, RST_TARGET_MASK};
    wd_count   = 32'd0;
    wd_running = 1'b0;
    wd_enabled = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: idle tick, ignored kick, repeated enable, expiry with no fallback.
    @(negedge clk);
    queue_cmd(CMD_TICK, 32'd0);
    queue_cmd(CMD_READ, 32'hFFFF_FFFF);
    queue_cmd(CMD_KICK, 32'd5);
    queue_cmd(CMD_ENABLE, 32'd1);
    queue_cmd(CMD_ENABLE, 32'hFFFF_FFFF);
    queue_cmd(CMD_KICK, 32'd2);
    queue_cmd(CMD_TICK, 32'd0);
    queue_cmd(CMD_TICK, 32'd0);
    queue_cmd(CMD_READ, 32'd0);
    queue_cmd(CMD_ENABLE, 32'hFFFF_FFFE);
    wait_quiet();

    // Zero interval and an always-on fallback stage: kicks there load its interval.
    apply_settings('{32'd0, 2'd0, 1'b1, 32'd2, 2'd2, 1'b1, 4'hF});
    @(negedge clk);
    queue_cmd(CMD_ENABLE, 32'd1);
    queue_cmd(CMD_TICK, 32'd0);
    queue_cmd(CMD_KICK, 32'hFFFF_FFFF);
    queue_cmd(CMD_TICK, 32'd0);
    queue_cmd(CMD_TICK, 32'd0);
    queue_cmd(CMD_ENABLE, 32'd0);
    queue_cmd(CMD_ENABLE, 32'd1);
    queue_cmd(CMD_KICK, 32'd0);
    queue_cmd(CMD_TICK, 32'd0);
    wait_quiet();

    // Largest times and no targets: the timeout stops without firing.
    apply_settings('{32'hFFFF_FFFF, 2'd3, 1'b1, 32'hFFFF_FFFF, 2'd3, 1'b0, 4'h0});
    @(negedge clk);
    queue_cmd(CMD_ENABLE, 32'd1);
    queue_cmd(CMD_TICK, 32'd0);
    queue_cmd(CMD_KICK, 32'd1);
    queue_cmd(CMD_TICK, 32'd0);
    queue_cmd(CMD_ENABLE, 32'd1);
    queue_cmd(CMD_ENABLE, 32'd0);
    wait_quiet();

    // Random phases, the first two at the extreme settings.
    for (int unsigned phase = 0; phase < RandPhases; phase++) begin
      if (phase == 0)      s = '{32'hFFFF_FFFF, 2'd3, 1'b1, 32'hFFFF_FFFF, 2'd3, 1'b1, 4'hF};
      else if (phase == 1) s = '0;
      else                 s = random_settings();
      apply_settings(s);
      @(negedge clk);
      pace = pace_t'(phase % 4);
      queue_random_commands(PhaseItems);
      wait_quiet();
    end

    // Back-pressure: the result side holds off while commands keep coming.
    apply_settings(random_settings());
    @(negedge clk);
    pace         = PACE_FULL;
    hold_request = 1'b1;
    queue_random_commands(80);
    wait_quiet();

    repeat (10) @(posedge clk);
    $display("Sent %0d commands under %0d register settings; %0d results checked.",
             cmds_accepted, settings_count, results_checked);
    $display("%0d timeouts fired an action; command input stalled for %0d cycles.",
             fired_count, input_stall_cycles);
    if (error_count == 0) begin
      $display("[watchdog_with_fallback_top] OK");
    end else begin
      $display("%0d mismatches found", error_count);
      $display("[watchdog_with_fallback_top] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/wdf_pkg.sv
rtl/wdf_if.sv
rtl/wdf_cfg_regs.sv
rtl/wdf_engine.sv
rtl/watchdog_with_fallback_top.sv
rtl/wdf_checker.sv
verif/tb_top.sv
